@@ rtl/kvt_pkg.sv @@
// Shared constants, types and helpers of the key/value table.
package kvt_pkg;

   // Number of slots in the table
   localparam int ENTRIES = 16;

   // Slot index and pair count widths
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Field widths fixed by the request format
   localparam int ACT_W = 2;
   localparam int DATA_W = 32;
   localparam int OUT_CNT_W = 5;

   // Request action codes
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

   // Write port of the slot store
   typedef struct packed {
      logic                     we_key;
      logic                     we_value;
      logic [IDX_W-1:0]         addr;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } wr_type;

   // One finished result, before the output register
   typedef struct packed {
      logic                     strobe;
      logic signed [DATA_W-1:0] value_out;
      logic                     found;
      logic                     table_full;
      logic [OUT_CNT_W-1:0]     entry_count;
      logic                     is_empty;
   } rsp_type;

   // Low bits of the pair count as reported on the result
   function automatic logic [OUT_CNT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+OUT_CNT_W-1:0] wide;
      wide = {{OUT_CNT_W{1'b0}}, cnt};
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage

@@ rtl/kvt_store.sv @@
// Key and value memories: one write port, one synchronous read port each.
module kvt_store (
   input  logic                               clock,
   input  kvt_pkg::wr_type                    wr,
   input  logic [kvt_pkg::IDX_W-1:0]          rd_addr,
   output logic signed [kvt_pkg::DATA_W-1:0]  rd_key,
   output logic signed [kvt_pkg::DATA_W-1:0]  rd_value
);

   logic signed [kvt_pkg::DATA_W-1:0] key_mem [kvt_pkg::ENTRIES];
   logic signed [kvt_pkg::DATA_W-1:0] val_mem [kvt_pkg::ENTRIES];
   logic signed [kvt_pkg::DATA_W-1:0] rd_key_ff;
   logic signed [kvt_pkg::DATA_W-1:0] rd_value_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.we_key) begin
         key_mem[wr.addr] <= wr.key;
      end
      if (wr.we_value) begin
         val_mem[wr.addr] <= wr.value;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= val_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

@@ rtl/kvt_seq.sv @@
// Request sequencer: slot scan, compare, valid bits, pair count and write-back.
module kvt_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [kvt_pkg::ACT_W-1:0]          action,
   input  logic signed [kvt_pkg::DATA_W-1:0]  key,
   input  logic signed [kvt_pkg::DATA_W-1:0]  value,
   output logic                               busy,
   output logic [kvt_pkg::IDX_W-1:0]          rd_addr,
   input  logic signed [kvt_pkg::DATA_W-1:0]  rd_key,
   input  logic signed [kvt_pkg::DATA_W-1:0]  rd_value,
   output kvt_pkg::wr_type                    wr,
   output kvt_pkg::rsp_type                   rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   localparam logic [kvt_pkg::IDX_W-1:0] LAST_IDX = kvt_pkg::IDX_W'(kvt_pkg::ENTRIES - 1);

   logic [1:0]                        state_ff, state_in;
   logic [kvt_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [kvt_pkg::IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                              cmp_ok_ff, cmp_ok_in;
   logic [kvt_pkg::ACT_W-1:0]         action_ff, action_in;
   logic signed [kvt_pkg::DATA_W-1:0] key_ff, key_in;
   logic signed [kvt_pkg::DATA_W-1:0] value_ff, value_in;
   logic                              hit_ff, hit_in;
   logic [kvt_pkg::IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic signed [kvt_pkg::DATA_W-1:0] hit_val_ff, hit_val_in;
   logic                              free_ok_ff, free_ok_in;
   logic [kvt_pkg::IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [kvt_pkg::ENTRIES-1:0]       valid_ff, valid_in;
   logic [kvt_pkg::CNT_W-1:0]         cnt_ff, cnt_in;

   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = idx_ff;

   // Next-state and datapath logic
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_ok_in   = 1'b0;
      action_in   = action_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_val_in  = hit_val_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      wr          = '0;
      rsp         = '0;

      // Compare the slot whose data came back this cycle
      if (cmp_ok_ff) begin
         if (valid_ff[cmp_idx_ff]) begin
            if (!hit_ff && rd_key == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               hit_val_in = rd_value;
            end
         end else if (!free_ok_ff) begin
            free_ok_in  = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in  = action;
               key_in     = key;
               value_in   = value;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               idx_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_ok_in  = 1'b1;
            cmp_idx_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr.key   = key_ff;
            wr.value = value_ff;
            unique case (action_ff)
               kvt_pkg::ACT_INSERT: begin
                  if (hit_ff) begin
                     wr.we_value   = 1'b1;
                     wr.addr       = hit_idx_ff;
                     rsp.found     = 1'b1;
                     rsp.value_out = hit_val_ff;
                  end else if (free_ok_ff) begin
                     wr.we_key             = 1'b1;
                     wr.we_value           = 1'b1;
                     wr.addr               = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     cnt_in                = cnt_ff + 1'b1;
                  end else begin
                     rsp.table_full = 1'b1;
                  end
               end
               kvt_pkg::ACT_LOOKUP: begin
                  if (hit_ff) begin
                     rsp.found     = 1'b1;
                     rsp.value_out = hit_val_ff;
                  end
               end
               kvt_pkg::ACT_REMOVE: begin
                  if (hit_ff) begin
                     rsp.found            = 1'b1;
                     rsp.value_out        = hit_val_ff;
                     valid_in[hit_idx_ff] = 1'b0;
                     if (cnt_ff != '0) begin
                        cnt_in = cnt_ff - 1'b1;
                     end
                  end
               end
               default: begin
                  // unused action leaves the table alone
               end
            endcase
            rsp.strobe      = 1'b1;
            rsp.entry_count = kvt_pkg::count_out(cnt_in);
            rsp.is_empty    = (cnt_in == '0);
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cmp_ok_ff <= 1'b0;
         valid_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cmp_ok_ff <= cmp_ok_in;
         valid_ff  <= valid_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Request and scan payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      action_ff   <= action_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
   end

endmodule

@@ rtl/key_value_table_unit.sv @@
// Top level of the key/value table: sequencer, slot store and result register.
//
// A request (action, key, value) is taken at a rising edge where start is high
// and busy is low. Actions: insert or update, lookup, remove; other codes only
// report the table. Each request gives exactly one result, shown on the rsp_
// ports for one cycle with rsp_strobe high; the receiver cannot stall it.
// The scan reads one slot per cycle through the single read port of the
// key/value memories; a drain state waits for the last read data, then a
// write-back state updates the table and the result is registered. A new
// request is taken only once busy is low again after the last write-back.
// Keys and values sit in synchronous memories; valid bits and the pair count
// are flip-flops. Reset clears the valid bits, the pair count and the
// sequencer, so the table is empty and ready as soon as reset is released;
// the memory contents are not cleared and are never used while invalid.
module key_value_table_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [kvt_pkg::ACT_W-1:0]               req_action,
   input  logic signed [kvt_pkg::DATA_W-1:0]       req_key,
   input  logic signed [kvt_pkg::DATA_W-1:0]       req_value,
   output logic                                    rsp_strobe,
   output logic signed [kvt_pkg::DATA_W-1:0]       rsp_value_out,
   output logic                                    rsp_found,
   output logic                                    rsp_table_full,
   output logic [kvt_pkg::OUT_CNT_W-1:0]           rsp_entry_count,
   output logic                                    rsp_is_empty
);

   kvt_pkg::wr_type                   wr;
   kvt_pkg::rsp_type                  rsp_in;
   kvt_pkg::rsp_type                  rsp_ff;
   logic [kvt_pkg::IDX_W-1:0]         rd_addr;
   logic signed [kvt_pkg::DATA_W-1:0] rd_key;
   logic signed [kvt_pkg::DATA_W-1:0] rd_value;

   kvt_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .action   (req_action),
      .key      (req_key),
      .value    (req_value),
      .busy     (busy),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .wr       (wr),
      .rsp      (rsp_in)
   );

   kvt_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   // Result register; only the strobe needs reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.strobe <= 1'b0;
      end else begin
         rsp_ff.strobe <= rsp_in.strobe;
      end
      rsp_ff.value_out   <= rsp_in.value_out;
      rsp_ff.found       <= rsp_in.found;
      rsp_ff.table_full  <= rsp_in.table_full;
      rsp_ff.entry_count <= rsp_in.entry_count;
      rsp_ff.is_empty    <= rsp_in.is_empty;
   end

   assign rsp_strobe      = rsp_ff.strobe;
   assign rsp_value_out   = rsp_ff.value_out;
   assign rsp_found       = rsp_ff.found;
   assign rsp_table_full  = rsp_ff.table_full;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_is_empty    = rsp_ff.is_empty;

   // An accepted request keeps the block busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // A result is shown only after the sequencer has gone idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while a request is in work");

   // A refused insert reports no hit and no value
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_table_full) |-> (!rsp_found && rsp_value_out == '0))
      else $error("refused insert reports a hit");

   // No result is produced without a request in work just before it
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a request in work");

endmodule
